// ===== hdl/nspl_pkg.sv =====
`default_nettype none
package nspl_pkg;

    localparam int STORE_DEPTH  = 256;
    localparam int NOTE_ID_BITS = 16;
    localparam int IDX_W        = $clog2(STORE_DEPTH);
    localparam int CNT_W        = $clog2(STORE_DEPTH + 1);

    localparam logic [2:0] CMD_CLEAR    = 3'd0;
    localparam logic [2:0] CMD_APPEND   = 3'd1;
    localparam logic [2:0] CMD_QUERY_ID = 3'd2;
    localparam logic [2:0] CMD_QUERY_PS = 3'd3;
    localparam logic [2:0] CMD_COMMIT   = 3'd4;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FOUND = 2'd1;
    localparam logic [1:0] ST_MISS  = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    localparam logic [1:0] KIND_ON  = 2'd0;
    localparam logic [1:0] KIND_OFF = 2'd1;

    typedef logic [NOTE_ID_BITS-1:0] id_t;

    typedef struct packed {
        id_t        id;
        logic       idv;
        logic [6:0] vel;
        logic [6:0] pitch;
        logic [3:0] ch;
        logic [1:0] kind;
    } ev_t;

    typedef enum logic [2:0] {
        MODE_FIND_ID,
        MODE_FIND_PS,
        MODE_OFF_ID,
        MODE_OFF_PS,
        MODE_LIFO
    } mode_t;

    typedef enum logic [1:0] {
        FIN_NONE,
        FIN_OFF,
        FIN_LIFO,
        FIN_MISS
    } fin_t;

    typedef struct packed {
        logic  accept;
        logic  idx_clr;
        logic  idx_inc;
        mode_t mode;
        logic  pass1;
        logic  eval;
        logic  on_from_loc;
        logic  key_from_rd;
        logic  off_clr;
        logic  stk_clr;
        logic  stk_load_k;
        logic  stk_dec;
        logic  stk_kill;
        fin_t  fin;
        logic  out_load;
    } ctl_cmd_t;

    typedef struct packed {
        logic scan_end;
        logic find_hit;
        logic hit_idv;
        logic lifo_end_ev;
        logic off_found;
        logic stk_empty;
        logic stk_take;
        logic stk_match;
        logic out_free;
    } ctl_st_t;

endpackage
`default_nettype wire

// ===== hdl/nspl_ctrl.sv =====
`default_nettype none
module nspl_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [2:0]        s_command,
    input  wire logic              s_note_id_valid,
    input  wire nspl_pkg::ctl_st_t st,
    output nspl_pkg::ctl_cmd_t     cmd
);
    import nspl_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE    = 11'b00000000001,
        S_FIND_RD = 11'b00000000010,
        S_FIND_EV = 11'b00000000100,
        S_OFF_RD  = 11'b00000001000,
        S_OFF_EV  = 11'b00000010000,
        S_LIFO_RD = 11'b00000100000,
        S_LIFO_EV = 11'b00001000000,
        S_STK_RD  = 11'b00010000000,
        S_STK_EV  = 11'b00100000000,
        S_DONE    = 11'b01000000000,
        S_SPARE   = 11'b10000000000
    } state_t;

    state_t     state_reg, state_next;
    mode_t      mode_reg, mode_next;
    logic       pass_reg, pass_next;
    logic       fb_reg, fb_next;
    logic [2:0] cmd_reg, cmd_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        mode_next  = mode_reg;
        pass_next  = pass_reg;
        fb_next    = fb_reg;
        cmd_next   = cmd_reg;
        cmd        = '0;
        cmd.mode   = mode_reg;
        cmd.pass1  = pass_reg;
        cmd.fin    = FIN_NONE;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    cmd_next   = s_command;
                    pass_next  = 1'b0;
                    fb_next    = 1'b0;
                    cmd.idx_clr = 1'b1;
                    state_next = S_DONE;
                    if (s_command == CMD_QUERY_ID && s_note_id_valid) begin
                        mode_next  = MODE_FIND_ID;
                        state_next = S_FIND_RD;
                    end else if (s_command == CMD_QUERY_PS || s_command == CMD_COMMIT) begin
                        mode_next  = MODE_FIND_PS;
                        state_next = S_FIND_RD;
                    end
                end
            end
            S_FIND_RD: begin
                if (!st.scan_end) begin
                    state_next = S_FIND_EV;
                end else if (!pass_reg) begin
                    pass_next   = 1'b1;
                    cmd.idx_clr = 1'b1;
                end else if (mode_reg == MODE_FIND_ID && fb_reg) begin
                    fb_next         = 1'b0;
                    cmd.on_from_loc = 1'b1;
                    cmd.off_clr     = 1'b1;
                    cmd.idx_clr     = 1'b1;
                    mode_next       = MODE_OFF_PS;
                    state_next      = S_OFF_RD;
                end else begin
                    cmd.fin    = FIN_MISS;
                    state_next = S_DONE;
                end
            end
            S_FIND_EV: begin
                cmd.eval = 1'b1;
                if (!st.find_hit) begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_FIND_RD;
                end else if (mode_reg == MODE_FIND_ID) begin
                    cmd.off_clr = 1'b1;
                    cmd.idx_clr = 1'b1;
                    mode_next   = MODE_OFF_ID;
                    state_next  = S_OFF_RD;
                end else if (cmd_reg == CMD_COMMIT) begin
                    cmd.stk_clr = 1'b1;
                    cmd.idx_clr = 1'b1;
                    mode_next   = MODE_LIFO;
                    state_next  = S_LIFO_RD;
                end else if (st.hit_idv) begin
                    cmd.key_from_rd = 1'b1;
                    cmd.idx_clr     = 1'b1;
                    pass_next       = 1'b0;
                    fb_next         = 1'b1;
                    mode_next       = MODE_FIND_ID;
                    state_next      = S_FIND_RD;
                end else begin
                    cmd.off_clr = 1'b1;
                    cmd.idx_clr = 1'b1;
                    mode_next   = MODE_OFF_PS;
                    state_next  = S_OFF_RD;
                end
            end
            S_OFF_RD: begin
                if (!st.scan_end) begin
                    state_next = S_OFF_EV;
                end else if (st.off_found) begin
                    cmd.fin    = FIN_OFF;
                    state_next = S_DONE;
                end else begin
                    cmd.stk_clr = 1'b1;
                    cmd.idx_clr = 1'b1;
                    mode_next   = MODE_LIFO;
                    state_next  = S_LIFO_RD;
                end
            end
            S_OFF_EV: begin
                cmd.eval    = 1'b1;
                cmd.idx_inc = 1'b1;
                state_next  = S_OFF_RD;
            end
            S_LIFO_RD: begin
                if (!st.scan_end) begin
                    state_next = S_LIFO_EV;
                end else if (fb_reg) begin
                    fb_next         = 1'b0;
                    cmd.on_from_loc = 1'b1;
                    cmd.off_clr     = 1'b1;
                    cmd.idx_clr     = 1'b1;
                    mode_next       = MODE_OFF_PS;
                    state_next      = S_OFF_RD;
                end else begin
                    cmd.fin    = FIN_MISS;
                    state_next = S_DONE;
                end
            end
            S_LIFO_EV: begin
                cmd.eval    = 1'b1;
                cmd.idx_inc = 1'b1;
                if (st.lifo_end_ev) begin
                    cmd.stk_load_k = 1'b1;
                    state_next     = S_STK_RD;
                end else begin
                    state_next = S_LIFO_RD;
                end
            end
            S_STK_RD: begin
                state_next = st.stk_empty ? S_LIFO_RD : S_STK_EV;
            end
            S_STK_EV: begin
                if (st.stk_take) begin
                    cmd.stk_kill = 1'b1;
                    if (st.stk_match) begin
                        cmd.fin    = FIN_LIFO;
                        state_next = S_DONE;
                    end else begin
                        state_next = S_LIFO_RD;
                    end
                end else begin
                    cmd.stk_dec = 1'b1;
                    state_next  = S_STK_RD;
                end
            end
            S_DONE: begin
                if (st.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            mode_reg  <= MODE_FIND_ID;
            pass_reg  <= 1'b0;
            fb_reg    <= 1'b0;
            cmd_reg   <= CMD_CLEAR;
        end else begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            pass_reg  <= pass_next;
            fb_reg    <= fb_next;
            cmd_reg   <= cmd_next;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/nspl_dp.sv =====
`default_nettype none
module nspl_dp (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire nspl_pkg::ctl_cmd_t cmd,
    output nspl_pkg::ctl_st_t       st,
    input  wire logic               cfg_we,
    input  wire logic [31:0]        cfg_wdata,
    input  wire logic [2:0]         s_command,
    input  wire logic [1:0]         s_event_kind,
    input  wire logic [3:0]         s_channel,
    input  wire logic [6:0]         s_pitch,
    input  wire logic [6:0]         s_velocity,
    input  wire logic [31:0]        s_tick,
    input  wire logic [15:0]        s_note_id,
    input  wire logic               s_note_id_valid,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [1:0]              m_status,
    output logic [6:0]              m_span_pitch,
    output logic [6:0]              m_span_velocity,
    output logic [31:0]             m_start_tick,
    output logic [31:0]             m_end_tick,
    output logic [15:0]             m_found_note_id,
    output logic                    m_found_note_id_valid
);
    import nspl_pkg::*;

    typedef struct packed {
        logic [31:0] tick;
        ev_t         ev;
    } entry_t;

    typedef struct packed {
        logic        alive;
        logic        match;
        logic [31:0] tick;
    } stk_t;

    entry_t store_mem [STORE_DEPTH];
    stk_t   stk_mem [STORE_DEPTH];

    entry_t rd_reg;
    stk_t   srd_reg;

    logic [CNT_W-1:0] count_reg, idx_reg, sp_reg, k_reg;
    logic [31:0]      loop_reg;
    logic [2:0]       q_cmd_reg;
    logic [3:0]       q_ch_reg;
    logic [6:0]       q_pitch_reg;
    logic [31:0]      q_tick_reg;
    id_t              key_reg;
    ev_t              on_reg, loc_reg;
    logic [31:0]      on_tick_reg, off_tick_reg, cur_tick_reg;
    logic             off_found_reg;

    logic [1:0]  res_status_reg;
    logic [6:0]  res_pitch_reg, res_vel_reg;
    logic [31:0] res_start_reg, res_end_reg;
    id_t         res_fid_reg;
    logic        res_fidv_reg;
    logic        m_valid_reg;

    ev_t         e;
    logic [31:0] e_tick;
    logic        e_start, e_end, ch_ok, lifo_sel, off_base, off_later;
    logic        hit_id, hit_ps, off_id_ok, off_ps_ok, push_match, full;
    logic        commit_bad, found_lifo;
    logic [32:0] limit;
    ev_t         in_ev;
    logic [IDX_W-1:0] k_addr;

    assign e        = rd_reg.ev;
    assign e_tick   = rd_reg.tick;
    assign e_start  = (e.kind == KIND_ON) && (e.vel != 7'd0);
    assign e_end    = (e.kind == KIND_OFF);
    assign ch_ok    = cmd.pass1 || (e.ch == q_ch_reg);
    assign hit_id   = ch_ok && e.idv && (e.id == key_reg) && e_start;
    assign hit_ps   = ch_ok && e_start && (e.pitch == q_pitch_reg) && (e_tick == q_tick_reg);
    assign lifo_sel = (e.ch == on_reg.ch) && (e.pitch == on_reg.pitch);
    assign off_base = e_end && lifo_sel && (e_tick > on_tick_reg);
    assign off_later = !off_found_reg || (e_tick > off_tick_reg);
    assign off_id_ok = off_base && e.idv && (e.id == key_reg) && off_later;
    assign off_ps_ok = off_base && !(e.idv && !(on_reg.idv && e.id == on_reg.id)) && off_later;
    assign push_match = (e.idv == on_reg.idv) && (e.id == on_reg.id) && (e_tick == on_tick_reg);
    assign full     = (count_reg >= CNT_W'(STORE_DEPTH));
    assign k_addr   = IDX_W'(k_reg - CNT_W'(1));
    assign limit    = {1'b0, on_tick_reg} + {1'b0, loop_reg};
    assign commit_bad = (q_cmd_reg == CMD_COMMIT) &&
                        ((cur_tick_reg <= on_tick_reg) ||
                         ((loop_reg != 32'd0) && ({1'b0, cur_tick_reg} > limit)));
    assign found_lifo = !commit_bad;

    always_comb begin
        in_ev       = '0;
        in_ev.kind  = s_event_kind;
        in_ev.ch    = s_channel;
        in_ev.pitch = s_pitch;
        in_ev.vel   = s_velocity;
        in_ev.idv   = s_note_id_valid;
        in_ev.id    = s_note_id_valid ? id_t'(s_note_id) : '0;
    end

    always_comb begin
        st             = '0;
        st.scan_end    = (idx_reg >= count_reg);
        st.find_hit    = (cmd.mode == MODE_FIND_ID) ? hit_id : hit_ps;
        st.hit_idv     = e.idv;
        st.lifo_end_ev = lifo_sel && e_end;
        st.off_found   = off_found_reg;
        st.stk_empty   = (k_reg == '0);
        st.stk_take    = srd_reg.alive && (cur_tick_reg > srd_reg.tick);
        st.stk_match   = srd_reg.match;
        st.out_free    = !m_valid_reg || m_ready;
    end

    always_ff @(posedge aclk) begin
        rd_reg  <= store_mem[idx_reg[IDX_W-1:0]];
        srd_reg <= stk_mem[k_addr];
        if (cmd.accept && s_command == CMD_APPEND && !full) begin
            store_mem[count_reg[IDX_W-1:0]] <= '{tick: s_tick, ev: in_ev};
        end
        if (cmd.eval && cmd.mode == MODE_LIFO && lifo_sel && e_start) begin
            stk_mem[sp_reg[IDX_W-1:0]] <= '{alive: 1'b1, match: push_match, tick: e_tick};
        end else if (cmd.stk_kill) begin
            stk_mem[k_addr] <= '{alive: 1'b0, match: srd_reg.match, tick: srd_reg.tick};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            sp_reg      <= '0;
            loop_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                loop_reg <= cfg_wdata;
            end
            if (cmd.accept) begin
                if (s_command == CMD_CLEAR) begin
                    count_reg <= '0;
                end else if (s_command == CMD_APPEND && !full) begin
                    count_reg <= count_reg + CNT_W'(1);
                end
            end
            if (cmd.stk_clr) begin
                sp_reg <= '0;
            end else if (cmd.eval && cmd.mode == MODE_LIFO && lifo_sel && e_start) begin
                sp_reg <= sp_reg + CNT_W'(1);
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.idx_clr) begin
            idx_reg <= '0;
        end else if (cmd.idx_inc) begin
            idx_reg <= idx_reg + CNT_W'(1);
        end
        if (cmd.stk_load_k) begin
            k_reg <= sp_reg;
        end else if (cmd.stk_dec) begin
            k_reg <= k_reg - CNT_W'(1);
        end
        if (cmd.accept) begin
            q_cmd_reg      <= s_command;
            q_ch_reg       <= s_channel;
            q_pitch_reg    <= s_pitch;
            q_tick_reg     <= s_tick;
            key_reg        <= in_ev.id;
            res_status_reg <= (s_command == CMD_APPEND && full) ? ST_FULL :
                              (s_command == CMD_QUERY_ID && !s_note_id_valid) ? ST_MISS :
                              ST_DONE;
            res_pitch_reg  <= '0;
            res_vel_reg    <= '0;
            res_start_reg  <= '0;
            res_end_reg    <= '0;
            res_fid_reg    <= '0;
            res_fidv_reg   <= 1'b0;
        end
        if (cmd.key_from_rd) begin
            key_reg <= e.id;
        end
        if (cmd.on_from_loc) begin
            on_reg      <= loc_reg;
            on_tick_reg <= q_tick_reg;
        end
        if (cmd.off_clr) begin
            off_found_reg <= 1'b0;
        end
        if (cmd.eval) begin
            case (cmd.mode)
                MODE_FIND_ID: begin
                    if (hit_id) begin
                        on_reg      <= e;
                        on_tick_reg <= e_tick;
                    end
                end
                MODE_FIND_PS: begin
                    if (hit_ps) begin
                        on_reg      <= e;
                        loc_reg     <= e;
                        on_tick_reg <= e_tick;
                    end
                end
                MODE_OFF_ID: begin
                    if (off_id_ok) begin
                        off_found_reg <= 1'b1;
                        off_tick_reg  <= e_tick;
                    end
                end
                MODE_OFF_PS: begin
                    if (off_ps_ok) begin
                        off_found_reg <= 1'b1;
                        off_tick_reg  <= e_tick;
                    end
                end
                MODE_LIFO: begin
                    if (lifo_sel && e_end) begin
                        cur_tick_reg <= e_tick;
                    end
                end
                default: begin
                end
            endcase
        end
        case (cmd.fin)
            FIN_OFF, FIN_LIFO: begin
                if (cmd.fin == FIN_OFF || found_lifo) begin
                    res_status_reg <= ST_FOUND;
                    res_pitch_reg  <= on_reg.pitch;
                    res_vel_reg    <= on_reg.vel;
                    res_start_reg  <= on_tick_reg;
                    res_end_reg    <= (cmd.fin == FIN_OFF) ? off_tick_reg : cur_tick_reg;
                    if (q_cmd_reg != CMD_QUERY_ID) begin
                        res_fid_reg  <= loc_reg.id;
                        res_fidv_reg <= loc_reg.idv;
                    end
                end else begin
                    res_status_reg <= ST_MISS;
                end
            end
            FIN_MISS: begin
                res_status_reg <= ST_MISS;
            end
            default: begin
            end
        endcase
        if (cmd.out_load) begin
            m_status              <= res_status_reg;
            m_span_pitch          <= res_pitch_reg;
            m_span_velocity       <= res_vel_reg;
            m_start_tick          <= res_start_reg;
            m_end_tick            <= res_end_reg;
            m_found_note_id       <= 16'(res_fid_reg);
            m_found_note_id_valid <= res_fidv_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule
`default_nettype wire

// ===== hdl/note_span_pairing_lookup.sv =====
`default_nettype none
// Note event store with span lookup. A query runs a sequencer over the event
// store, reading each entry through the registered store read port: up to two
// passes to locate the note-on, a note-off scan (skipped for a commit) and, where
// that finds none, a last-in-first-out pairing walk that for each matching
// note-off also walks the pairing stack top down. A pitch-start query on a
// note-on with an identity may run the locate, note-off and pairing scans twice.
// A new word is taken while the previous result still waits on the m_ side.
module note_span_pairing_lookup (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_command,
    input  wire logic [1:0]  s_event_kind,
    input  wire logic [3:0]  s_channel,
    input  wire logic [6:0]  s_pitch,
    input  wire logic [6:0]  s_velocity,
    input  wire logic [31:0] s_tick,
    input  wire logic [15:0] s_note_id,
    input  wire logic        s_note_id_valid,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic [6:0]       m_span_pitch,
    output logic [6:0]       m_span_velocity,
    output logic [31:0]      m_start_tick,
    output logic [31:0]      m_end_tick,
    output logic [15:0]      m_found_note_id,
    output logic             m_found_note_id_valid
);
    import nspl_pkg::*;

    ctl_cmd_t cmd;
    ctl_st_t  st;

    nspl_ctrl u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_note_id_valid (s_note_id_valid),
        .st              (st),
        .cmd             (cmd)
    );

    nspl_dp u_dp (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cmd                   (cmd),
        .st                    (st),
        .cfg_we                (cfg_we),
        .cfg_wdata             (cfg_wdata),
        .s_command             (s_command),
        .s_event_kind          (s_event_kind),
        .s_channel             (s_channel),
        .s_pitch               (s_pitch),
        .s_velocity            (s_velocity),
        .s_tick                (s_tick),
        .s_note_id             (s_note_id),
        .s_note_id_valid       (s_note_id_valid),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_status              (m_status),
        .m_span_pitch          (m_span_pitch),
        .m_span_velocity       (m_span_velocity),
        .m_start_tick          (m_start_tick),
        .m_end_tick            (m_end_tick),
        .m_found_note_id       (m_found_note_id),
        .m_found_note_id_valid (m_found_note_id_valid)
    );

endmodule
`default_nettype wire

// ===== bench/note_span_pairing_lookup_check.sv =====
module note_span_pairing_lookup_check (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [2:0]  s_command,
    input  logic [1:0]  s_event_kind,
    input  logic [3:0]  s_channel,
    input  logic [6:0]  s_pitch,
    input  logic [6:0]  s_velocity,
    input  logic [31:0] s_tick,
    input  logic [15:0] s_note_id,
    input  logic        s_note_id_valid,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_status,
    input  logic [6:0]  m_span_pitch,
    input  logic [6:0]  m_span_velocity,
    input  logic [31:0] m_start_tick,
    input  logic [31:0] m_end_tick,
    input  logic [15:0] m_found_note_id,
    input  logic        m_found_note_id_valid,
    output int          errors,
    output int          outstanding,
    output int          words,
    output int          hits
);
    import nspl_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic [6:0]  pitch;
        logic [6:0]  vel;
        logic [31:0] start_t;
        logic [31:0] end_t;
        logic [15:0] fid;
        logic        fidv;
    } span_result_t;

    typedef struct {
        logic [6:0]  pitch;
        logic [6:0]  vel;
        logic [31:0] start_t;
        logic [31:0] end_t;
    } span_t;

    logic [31:0] ev_tick [STORE_DEPTH];
    logic [1:0]  ev_kind [STORE_DEPTH];
    logic [3:0]  ev_ch   [STORE_DEPTH];
    logic [6:0]  ev_pitch[STORE_DEPTH];
    logic [6:0]  ev_vel  [STORE_DEPTH];
    logic        ev_idv  [STORE_DEPTH];
    logic [15:0] ev_id   [STORE_DEPTH];
    int          ev_count;
    logic [31:0] loop_len;
    span_result_t span_q[$];

    function automatic bit is_on(int i);
        return ev_kind[i] == KIND_ON && ev_vel[i] != 0;
    endfunction

    function automatic bit is_off(int i);
        return ev_kind[i] == KIND_OFF;
    endfunction

    function automatic bit same_note(int a, int b);
        return ev_idv[a] == ev_idv[b] && ev_id[a] == ev_id[b] &&
               ev_tick[a] == ev_tick[b] && ev_pitch[a] == ev_pitch[b];
    endfunction

    function automatic bit pair_lifo(int on, output logic [31:0] end_t);
        int stk[STORE_DEPTH];
        int depth;
        int cand;
        bit hit;
        depth = 0;
        hit = 0;
        end_t = 0;
        for (int i = 0; i < ev_count && !hit; i++) begin
            if (ev_ch[i] != ev_ch[on] || ev_pitch[i] != ev_pitch[on])
                continue;
            if (is_on(i)) begin
                if (depth < STORE_DEPTH) begin
                    stk[depth] = i;
                    depth++;
                end
            end else if (is_off(i)) begin
                for (int k = depth; k > 0; k--) begin
                    cand = stk[k-1];
                    if (ev_tick[i] <= ev_tick[cand])
                        continue;
                    for (int j = k - 1; j + 1 < depth; j++)
                        stk[j] = stk[j+1];
                    depth--;
                    if (same_note(cand, on)) begin
                        end_t = ev_tick[i];
                        hit = 1;
                    end
                    break;
                end
            end
        end
        return hit;
    endfunction

    function automatic bit span_by_id(logic [15:0] id, logic [3:0] ch, output span_t sp);
        int on;
        int off;
        logic [31:0] e;
        bit ok;
        on = -1;
        off = -1;
        sp = '{default: 0};
        for (int pass = 0; pass < 2 && on < 0; pass++)
            for (int i = 0; i < ev_count; i++)
                if ((pass == 1 || ev_ch[i] == ch) && ev_idv[i] && ev_id[i] == id && is_on(i)) begin
                    on = i;
                    break;
                end
        if (on < 0)
            return 0;
        for (int i = 0; i < ev_count; i++) begin
            if (!is_off(i) || ev_ch[i] != ev_ch[on] || !ev_idv[i] || ev_id[i] != id ||
                ev_tick[i] <= ev_tick[on] || ev_pitch[i] != ev_pitch[on])
                continue;
            if (off < 0 || ev_tick[i] > ev_tick[off])
                off = i;
        end
        sp.pitch = ev_pitch[on];
        sp.vel = ev_vel[on];
        sp.start_t = ev_tick[on];
        if (off >= 0) begin
            sp.end_t = ev_tick[off];
            return 1;
        end
        ok = pair_lifo(on, e);
        sp.end_t = e;
        return ok;
    endfunction

    function automatic int find_start(logic [3:0] ch, logic [6:0] p, logic [31:0] t);
        for (int pass = 0; pass < 2; pass++)
            for (int i = 0; i < ev_count; i++)
                if ((pass == 1 || ev_ch[i] == ch) && is_on(i) && ev_pitch[i] == p &&
                    ev_tick[i] == t)
                    return i;
        return -1;
    endfunction

    function automatic bit span_pitch_start(int on, logic [3:0] ch, output span_t sp);
        int off;
        logic [31:0] e;
        bit ok;
        off = -1;
        if (ev_idv[on] && span_by_id(ev_id[on], ch, sp))
            return 1;
        sp = '{default: 0};
        for (int i = 0; i < ev_count; i++) begin
            if (!is_off(i) || ev_ch[i] != ev_ch[on] || ev_tick[i] <= ev_tick[on] ||
                ev_pitch[i] != ev_pitch[on])
                continue;
            if (ev_idv[i] && !(ev_idv[on] && ev_id[i] == ev_id[on]))
                continue;
            if (off < 0 || ev_tick[i] > ev_tick[off])
                off = i;
        end
        sp.pitch = ev_pitch[on];
        sp.vel = ev_vel[on];
        sp.start_t = ev_tick[on];
        if (off >= 0) begin
            sp.end_t = ev_tick[off];
            return 1;
        end
        ok = pair_lifo(on, e);
        sp.end_t = e;
        return ok;
    endfunction

    function automatic bit span_committed(int on, output span_t sp);
        logic [31:0] e;
        sp = '{default: 0};
        if (!pair_lifo(on, e))
            return 0;
        if (e <= ev_tick[on])
            return 0;
        if (loop_len != 0 && {1'b0, e} > {1'b0, ev_tick[on]} + {1'b0, loop_len})
            return 0;
        sp.pitch = ev_pitch[on];
        sp.vel = ev_vel[on];
        sp.start_t = ev_tick[on];
        sp.end_t = e;
        return 1;
    endfunction

    function automatic span_result_t predict_span(logic [2:0] cmd, logic [1:0] kind,
        logic [3:0] ch, logic [6:0] p, logic [6:0] v, logic [31:0] t, logic [15:0] id,
        logic idv);
        span_result_t r;
        span_t sp;
        bit found;
        int on;
        r = '0;
        found = 0;
        on = -1;
        sp = '{default: 0};
        if (!idv)
            id = 0;
        case (cmd)
            CMD_CLEAR: ev_count = 0;
            CMD_APPEND: begin
                if (ev_count >= STORE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    ev_tick[ev_count] = t;
                    ev_kind[ev_count] = kind;
                    ev_ch[ev_count] = ch;
                    ev_pitch[ev_count] = p;
                    ev_vel[ev_count] = v;
                    ev_idv[ev_count] = idv;
                    ev_id[ev_count] = id;
                    ev_count++;
                end
            end
            CMD_QUERY_ID, CMD_QUERY_PS, CMD_COMMIT: begin
                if (cmd == CMD_QUERY_ID) begin
                    found = idv && span_by_id(id, ch, sp);
                end else begin
                    on = find_start(ch, p, t);
                    if (on >= 0)
                        found = (cmd == CMD_QUERY_PS) ? span_pitch_start(on, ch, sp)
                                                      : span_committed(on, sp);
                end
                if (found) begin
                    r.status = ST_FOUND;
                    r.pitch = sp.pitch;
                    r.vel = sp.vel;
                    r.start_t = sp.start_t;
                    r.end_t = sp.end_t;
                    if (on >= 0) begin
                        r.fid = ev_id[on];
                        r.fidv = ev_idv[on];
                    end
                end else begin
                    r.status = ST_MISS;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, name, exp_v, act_v);
            errors++;
        end
    endtask

    initial begin
        errors = 0;
        words = 0;
        hits = 0;
        ev_count = 0;
        loop_len = 0;
    end

    assign outstanding = span_q.size();

    always @(posedge aclk) begin
        span_result_t exp_r;
        if (!aresetn) begin
            ev_count = 0;
            loop_len = 0;
        end else begin
            if (cfg_we)
                loop_len = cfg_wdata;
            if (s_valid && s_ready) begin
                span_q.insert(span_q.size(), predict_span(s_command, s_event_kind, s_channel,
                    s_pitch, s_velocity, s_tick, s_note_id, s_note_id_valid));
                words++;
            end
            if (m_valid && m_ready) begin
                if (span_q.size() == 0) begin
                    $display("%0t: result word with nothing expected, status %0d",
                             $realtime, m_status);
                    errors++;
                end else begin
                    exp_r = span_q.pop_front();
                    if (exp_r.status == ST_FOUND)
                        hits++;
                    compare_field("status", exp_r.status, m_status);
                    compare_field("span_pitch", exp_r.pitch, m_span_pitch);
                    compare_field("span_velocity", exp_r.vel, m_span_velocity);
                    compare_field("start_tick", exp_r.start_t, m_start_tick);
                    compare_field("end_tick", exp_r.end_t, m_end_tick);
                    compare_field("found_note_id", exp_r.fid, m_found_note_id);
                    compare_field("found_note_id_valid", exp_r.fidv, m_found_note_id_valid);
                end
            end
        end
    end

endmodule

// ===== bench/note_span_pairing_lookup_test.sv =====
module note_span_pairing_lookup_test;
    import nspl_pkg::*;

    localparam int IDLE_LIMIT = 400000;
    localparam int WORD_GOAL  = 780;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_we = 0;
    logic [31:0] cfg_wdata = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [2:0]  s_command = 0;
    logic [1:0]  s_event_kind = 0;
    logic [3:0]  s_channel = 0;
    logic [6:0]  s_pitch = 0;
    logic [6:0]  s_velocity = 0;
    logic [31:0] s_tick = 0;
    logic [15:0] s_note_id = 0;
    logic        s_note_id_valid = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [1:0]  m_status;
    logic [6:0]  m_span_pitch;
    logic [6:0]  m_span_velocity;
    logic [31:0] m_start_tick;
    logic [31:0] m_end_tick;
    logic [15:0] m_found_note_id;
    logic        m_found_note_id_valid;

    int errors, outstanding, words, hits;
    int sent = 0;
    int idle_cycles = 0;
    bit quiet = 0;
    bit hold_go = 0;
    bit hold = 0;

    logic [3:0]  on_ch [64];
    logic [6:0]  on_pitch[64];
    logic [31:0] on_tick[64];
    logic [15:0] on_id [64];
    logic        on_idv[64];
    int          on_count;

    note_span_pairing_lookup u_top (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_command(s_command),
        .s_event_kind(s_event_kind), .s_channel(s_channel), .s_pitch(s_pitch),
        .s_velocity(s_velocity), .s_tick(s_tick), .s_note_id(s_note_id),
        .s_note_id_valid(s_note_id_valid), .m_valid(m_valid), .m_ready(m_ready),
        .m_status(m_status), .m_span_pitch(m_span_pitch),
        .m_span_velocity(m_span_velocity), .m_start_tick(m_start_tick),
        .m_end_tick(m_end_tick), .m_found_note_id(m_found_note_id),
        .m_found_note_id_valid(m_found_note_id_valid)
    );

    note_span_pairing_lookup_check u_check (.*);

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (!aresetn || hold)
            m_ready <= 0;
        else if (quiet)
            m_ready <= 1;
        else
            m_ready <= $urandom_range(0, 99) >= 19;
    end

    // hold off the result side long enough to back up the input
    initial begin
        wait (hold_go);
        @(posedge aclk);
        hold <= 1;
        repeat (3000) @(posedge aclk);
        hold <= 0;
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("note_span_pairing_lookup_test: FAIL");
            $finish;
        end
    end

    task automatic put_word(logic [2:0] c, logic [1:0] k, logic [3:0] ch, logic [6:0] p,
                            logic [6:0] v, logic [31:0] t, logic [15:0] id, logic iv);
        s_command <= c;
        s_event_kind <= k;
        s_channel <= ch;
        s_pitch <= p;
        s_velocity <= v;
        s_tick <= t;
        s_note_id <= id;
        s_note_id_valid <= iv;
        s_valid <= 1;
        do @(posedge aclk); while (!s_ready);
        sent++;
        if (!quiet && $urandom_range(0, 99) < 19) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_valid <= 0;
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_loop(logic [31:0] v);
        drain();
        cfg_we <= 1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 0;
    endtask

    task automatic phrase(int n_events, int n_queries);
        logic [31:0] t;
        logic [3:0]  ch;
        logic [6:0]  p;
        logic [15:0] id;
        logic        iv;
        int          r;
        int          pick;
        logic [2:0]  c;
        t = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 50);
        on_count = 0;
        put_word(CMD_CLEAR, 2'($urandom), 4'($urandom), 7'($urandom), 7'($urandom), $urandom,
                 16'($urandom), 1'($urandom));
        for (int i = 0; i < n_events; i++) begin
            r = $urandom_range(0, 99);
            t = $urandom_range(0, 19) == 0 ? t - $urandom_range(0, 10) : t + $urandom_range(0, 12);
            ch = $urandom_range(0, 9) == 0 ? 4'($urandom) : 4'($urandom_range(0, 2));
            p = $urandom_range(0, 9) == 0 ? 7'($urandom) : 7'(60 + $urandom_range(0, 2));
            id = $urandom_range(0, 9) == 0 ? 16'($urandom) : 16'($urandom_range(0, 4));
            iv = $urandom_range(0, 99) < 70;
            if (r < 45 || on_count == 0) begin
                put_word(CMD_APPEND, KIND_ON, ch, p, 7'($urandom_range(1, 127)), t, id, iv);
                if (on_count < 64) begin
                    on_ch[on_count] = ch;
                    on_pitch[on_count] = p;
                    on_tick[on_count] = t;
                    on_id[on_count] = id;
                    on_idv[on_count] = iv;
                    on_count++;
                end
            end else if (r < 87) begin
                pick = $urandom_range(0, on_count - 1);
                if ($urandom_range(0, 1))
                    id = on_id[pick];
                put_word(CMD_APPEND, KIND_OFF, on_ch[pick], on_pitch[pick], 7'($urandom), t,
                         id, iv);
            end else if (r < 95) begin
                put_word(CMD_APPEND, 2'($urandom_range(2, 3)), ch, p, 7'($urandom), t, id, iv);
            end else begin
                put_word(CMD_APPEND, KIND_ON, ch, p, 0, t, id, iv);
            end
        end
        for (int i = 0; i < n_queries; i++) begin
            pick = $urandom_range(0, on_count - 1);
            c = 3'($urandom_range(2, 4));
            if ($urandom_range(0, 29) == 0)
                c = 3'($urandom_range(5, 7));
            if ($urandom_range(0, 9) < 8)
                put_word(c, 2'($urandom),
                         $urandom_range(0, 9) == 0 ? 4'($urandom) : on_ch[pick],
                         on_pitch[pick], 7'($urandom), on_tick[pick], on_id[pick],
                         c == CMD_QUERY_ID ? 1'($urandom_range(0, 9) != 0) : 1'($urandom));
            else
                put_word(c, 2'($urandom), 4'($urandom), 7'($urandom), 7'($urandom), $urandom,
                         16'($urandom), 1'($urandom));
        end
    endtask

    initial begin
        logic [31:0] loops[5];
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        set_loop(0);

        put_word(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0);
        put_word(CMD_APPEND, KIND_ON, 15, 127, 127, 32'hFFFF_FFF0, 16'hFFFF, 1);
        put_word(CMD_APPEND, KIND_OFF, 15, 127, 127, 32'hFFFF_FFFF, 16'hFFFF, 1);
        put_word(CMD_APPEND, KIND_ON, 0, 0, 1, 0, 16'hFFFF, 0);
        put_word(CMD_APPEND, KIND_OFF, 0, 0, 0, 5, 16'h1234, 0);
        put_word(CMD_APPEND, 2'd3, 0, 0, 0, 7, 0, 0);
        put_word(CMD_APPEND, 2'd2, 0, 0, 0, 8, 0, 0);
        put_word(CMD_APPEND, KIND_ON, 0, 0, 0, 9, 0, 0);
        put_word(CMD_QUERY_ID, 0, 0, 0, 0, 0, 0, 0);
        put_word(CMD_QUERY_ID, 0, 15, 0, 0, 0, 16'hFFFF, 1);
        put_word(CMD_QUERY_ID, 0, 3, 0, 0, 0, 16'hFFFF, 1);
        put_word(CMD_QUERY_PS, 0, 0, 0, 0, 0, 0, 0);
        put_word(CMD_COMMIT, 0, 0, 0, 0, 0, 0, 0);
        put_word(CMD_QUERY_PS, 0, 15, 127, 0, 32'hFFFF_FFF0, 0, 0);
        put_word(CMD_COMMIT, 0, 7, 127, 0, 32'hFFFF_FFF0, 0, 0);
        put_word(CMD_QUERY_PS, 0, 0, 0, 0, 9, 0, 0);
        put_word(3'd5, 0, 0, 0, 0, 0, 0, 0);
        put_word(3'd6, 0, 0, 0, 0, 0, 0, 0);
        put_word(3'd7, 3, 15, 127, 127, 32'hFFFF_FFFF, 16'hFFFF, 1);
        set_loop(1);
        put_word(CMD_COMMIT, 0, 0, 0, 0, 0, 0, 0);
        put_word(CMD_COMMIT, 0, 15, 127, 0, 32'hFFFF_FFF0, 0, 0);
        set_loop(32'hFFFF_FFFF);
        put_word(CMD_COMMIT, 0, 15, 127, 0, 32'hFFFF_FFF0, 0, 0);
        put_word(CMD_COMMIT, 0, 0, 0, 0, 0, 0, 0);

        // fill the store, then overflow it
        put_word(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0);
        for (int i = 0; i < STORE_DEPTH; i++)
            put_word(CMD_APPEND, i[0] ? KIND_OFF : KIND_ON, 4'(i >> 7), 7'(i >> 1), 7'(i | 1),
                     32'(i), 16'(i), i[2]);
        put_word(CMD_APPEND, KIND_ON, 0, 0, 1, 0, 0, 0);
        put_word(CMD_QUERY_PS, 0, 0, 3, 0, 6, 0, 0);
        put_word(CMD_COMMIT, 0, 1, 70, 0, 140, 0, 0);

        hold_go = 1;
        for (int i = 0; i < 3; i++)
            phrase(14, 6);

        loops[0] = 0;
        loops[1] = 1;
        loops[2] = 32'hFFFF_FFFF;
        loops[3] = 10;
        loops[4] = 0;
        for (int ph = 0; sent < WORD_GOAL; ph++) begin
            if (ph % 4 == 0)
                set_loop(ph % 20 == 8 ? $urandom : loops[$urandom_range(0, 4)]);
            quiet = (ph >= 12 && ph < 18);
            phrase($urandom_range(4, 16), $urandom_range(3, 9));
        end
        quiet = 0;

        drain();
        repeat (20) @(posedge aclk);
        $display("Run covered %0d words, %0d spans found, loop limits from zero to full range.",
                 words, hits);
        if (errors == 0 && outstanding == 0)
            $display("note_span_pairing_lookup_test: PASS");
        else
            $display("note_span_pairing_lookup_test: FAIL");
        $finish;
    end

endmodule
